[rtl/aq_pkg.sv]
// Shared constants and controller/datapath interface types for the absmax int8 quantizer.
package aq_pkg;

   localparam int DEF_MAX_LEN     = 64;
   localparam int DEF_SAMPLE_BITS = 16;

   localparam int QUO_W       = 31;   // quotient register, holds 127 * 2^24 / peak
   localparam int SCALE_STEPS = 31;
   localparam int ELEM_STEPS  = 7;    // element quotient never exceeds 127
   localparam int SCALE_W     = 32;
   localparam int QUANT_W     = 8;
   localparam int TOTAL_W     = 14;
   localparam int STEP_W      = 5;
   localparam logic [6:0] QMAX_NUM = 7'd127;

   typedef struct packed {
      logic load;          // store accepted sample, track peak
      logic scale_load;    // seed divider with 127 * 2^24
      logic elem_load;     // seed divider with |sample| * 127
      logic div_step;      // one restoring division step
      logic scale_latch;   // round and hold the scale
      logic rd;            // read store at element index
      logic emit;          // round element, write result register
      logic clear;         // end of vector
   } aq_cmd_type;

   typedef struct packed {
      logic out_free;
      logic last_elem;
   } aq_sts_type;

endpackage

[rtl/aq_datapath.sv]
// Datapath: sample store, peak tracking, shared serial divider and result register.
module aq_datapath import aq_pkg::*; #(
   parameter int MAX_LEN     = DEF_MAX_LEN,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  aq_cmd_type               cmd,
   output aq_sts_type               sts,
   input  logic [SAMPLE_BITS-1:0]   sample,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [55:0]              rsp_tdata,   // quantized, scale_factor, running_total
   output logic                     rsp_tlast    // end_of_vector
);

   localparam int SB = SAMPLE_BITS;
   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CW = $clog2(MAX_LEN + 1);

   logic [SB-1:0]       store_mem [MAX_LEN];
   logic [SB-1:0]       rd_ff;
   logic [CW-1:0]       count_ff, idx_ff;
   logic [SB-1:0]       peak_ff;
   logic [SB-1:0]       rem_ff, rem_in;
   logic [QUO_W-1:0]    dvd_ff, dvd_in;
   logic [SCALE_W-1:0]  scale_ff;
   logic [TOTAL_W-1:0]  total_ff, total_in;

   logic [QUANT_W-1:0]  rsp_q_ff;
   logic [SCALE_W-1:0]  rsp_scale_ff;
   logic [TOTAL_W-1:0]  rsp_total_ff;
   logic                rsp_last_ff, rsp_valid_ff;

   logic [SB-1:0]       mag_in, mag_rd;
   logic [SB+6:0]       prod;
   logic [SB+1:0]       trial;
   logic                ge, round_up;
   logic [QUANT_W-1:0]  qm, q;

   assign mag_in = sample[SB-1] ? (~sample + SB'(1)) : sample;
   assign mag_rd = rd_ff[SB-1] ? (~rd_ff + SB'(1)) : rd_ff;
   assign prod   = {mag_rd, 7'd0} - {7'd0, mag_rd};

   assign trial  = {1'b0, rem_ff, dvd_ff[QUO_W-1]} - {2'b00, peak_ff};
   assign ge     = !trial[SB+1];

   always_comb begin
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      if (cmd.scale_load) begin
         rem_in = '0;
         dvd_in = {QMAX_NUM, {(QUO_W-7){1'b0}}};
      end else if (cmd.elem_load) begin
         rem_in = prod[SB+6:7];
         dvd_in = {prod[ELEM_STEPS-1:0], {(QUO_W-ELEM_STEPS){1'b0}}};
      end else if (cmd.div_step) begin
         rem_in = ge ? trial[SB-1:0] : {rem_ff[SB-2:0], dvd_ff[QUO_W-1]};
         dvd_in = {dvd_ff[QUO_W-2:0], ge};
      end
   end

   // round half to even on the remainder
   assign round_up = ({rem_ff, 1'b0} > {1'b0, peak_ff}) ||
                     (({rem_ff, 1'b0} == {1'b0, peak_ff}) && dvd_ff[0]);
   assign qm       = {1'b0, dvd_ff[ELEM_STEPS-1:0]} + QUANT_W'(round_up);
   assign q        = rd_ff[SB-1] ? (QUANT_W'(0) - qm) : qm;
   assign total_in = total_ff + {{(TOTAL_W-QUANT_W){q[QUANT_W-1]}}, q};

   assign sts.out_free  = !rsp_valid_ff || rsp_tready;
   assign sts.last_elem = (idx_ff + CW'(1)) == count_ff;

   always_ff @(posedge clock) begin
      if (cmd.load && (count_ff < CW'(MAX_LEN)))
         store_mem[count_ff[AW-1:0]] <= sample;
      if (cmd.rd)
         rd_ff <= store_mem[idx_ff[AW-1:0]];
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      if (cmd.scale_latch)
         scale_ff <= SCALE_W'({1'b0, dvd_ff}) + SCALE_W'(round_up);
      if (cmd.emit && sts.out_free) begin
         rsp_q_ff     <= q;
         rsp_scale_ff <= scale_ff;
         rsp_total_ff <= total_in;
         rsp_last_ff  <= sts.last_elem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         peak_ff      <= SB'(1);
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            count_ff <= '0;
            peak_ff  <= SB'(1);
         end else if (cmd.load && (count_ff < CW'(MAX_LEN))) begin
            count_ff <= count_ff + CW'(1);
            if (mag_in > peak_ff)
               peak_ff <= mag_in;
         end
         if (cmd.emit && sts.out_free) begin
            rsp_valid_ff <= 1'b1;
            idx_ff       <= cmd.clear ? '0 : idx_ff + CW'(1);
            total_ff     <= cmd.clear ? '0 : total_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_total_ff, rsp_scale_ff, rsp_q_ff};

endmodule

[rtl/aq_ctrl.sv]
// Controller: sequences load, scale division and per-element division and emit.
module aq_ctrl import aq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tlast,
   output logic        req_tready,
   input  aq_sts_type  sts,
   output aq_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_LOAD,
      S_SCALE,
      S_SCALE_FIN,
      S_READ,
      S_ELEM_LOAD,
      S_ELEM,
      S_EMIT
   } state_type;

   state_type         state_ff;
   logic [STEP_W-1:0] step_ff;

   assign req_tready = (state_ff == S_LOAD);

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_LOAD: begin
            cmd.load       = req_tvalid;
            cmd.scale_load = req_tvalid && req_tlast;
         end
         S_SCALE:     cmd.div_step = 1'b1;
         S_SCALE_FIN: cmd.scale_latch = 1'b1;
         S_READ:      cmd.rd = 1'b1;
         S_ELEM_LOAD: cmd.elem_load = 1'b1;
         S_ELEM:      cmd.div_step = 1'b1;
         S_EMIT: begin
            cmd.emit  = 1'b1;
            cmd.clear = sts.out_free && sts.last_elem;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         step_ff  <= '0;
      end else begin
         case (state_ff)
            S_LOAD: begin
               if (req_tvalid && req_tlast) begin
                  state_ff <= S_SCALE;
                  step_ff  <= STEP_W'(SCALE_STEPS - 1);
               end
            end
            S_SCALE: begin
               step_ff <= step_ff - STEP_W'(1);
               if (step_ff == '0)
                  state_ff <= S_SCALE_FIN;
            end
            S_SCALE_FIN: state_ff <= S_READ;
            S_READ:      state_ff <= S_ELEM_LOAD;
            S_ELEM_LOAD: begin
               state_ff <= S_ELEM;
               step_ff  <= STEP_W'(ELEM_STEPS - 1);
            end
            S_ELEM: begin
               step_ff <= step_ff - STEP_W'(1);
               if (step_ff == '0)
                  state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (sts.out_free)
                  state_ff <= sts.last_elem ? S_LOAD : S_READ;
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

endmodule

[rtl/absmax_int8_activation_quantizer_unit.sv]
// Top level of the absmax int8 activation quantizer.
//
// req channel: one signed Q8.8 sample per beat in req_tdata, req_tlast marks
// the final sample of a vector. Samples load at one per cycle while the unit
// tracks the peak magnitude (floored at one LSB). Samples beyond MAX_LEN are
// dropped, but a marked one still ends the vector.
// After the marked beat req_tready drops and the unit computes the scale
// 127 * 2^24 / peak with a restoring divider, one quotient bit per cycle,
// then rounds it, then emits one rsp beat per stored sample in order.
// Each element steps through store read, divider seed, 7 quotient bits
// of |sample| * 127 / peak on the same shared divider, round and emit.
// rsp beats carry the quantized value, the Q16.16 scale and the running sum;
// rsp_tlast flags the last element. A stalled receiver holds the result
// register and the element sequencer waits; nothing is lost.
// req_tready returns in the same cycle that the last result appears in the rsp register.
// Synchronous reset empties the store count, sets the peak to one LSB and
// drops any pending result.
module absmax_int8_activation_quantizer_unit import aq_pkg::*; #(
   parameter int MAX_LEN     = DEF_MAX_LEN,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     req_tdata,   // sample
   input  logic                                 req_tlast,   // last_sample
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [55:0]                          rsp_tdata,   // quantized, scale_factor, running_total
   output logic                                 rsp_tlast    // end_of_vector
);

   aq_cmd_type cmd;
   aq_sts_type sts;

   aq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   aq_datapath #(
      .MAX_LEN     (MAX_LEN),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .sample     (req_tdata[SAMPLE_BITS-1:0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
